>>> design/pidl_pkg.sv
`timescale 1ns / 1ps

package pidl_pkg;

    localparam int LIST_DEPTH = 16;
    localparam int IDX_W      = $clog2(LIST_DEPTH);
    localparam int CNT_W      = $clog2(LIST_DEPTH + 1);
    localparam int CAP_W      = 5;
    localparam int CMP_W      = (CNT_W > CAP_W) ? CNT_W : CAP_W;
    localparam int DATA_W     = 32;
    localparam int POS_W      = 16;
    localparam int OUT_IDX_W  = 4;
    localparam int OUT_CNT_W  = 5;
    localparam int S_TDATA_W  = 48;
    localparam int M_TDATA_W  = 48;

    typedef enum logic [1:0] {
        OP_INSERT = 2'd0,
        OP_DELETE = 2'd1,
        OP_DUMP   = 2'd2,
        OP_BAD    = 2'd3
    } opcode_t;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_FULL   = 2'd1,
        ST_EMPTY  = 2'd2,
        ST_BADPOS = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        CELL_HOLD,
        CELL_LOAD_LEFT,
        CELL_LOAD_RIGHT,
        CELL_LOAD_HEAD,
        CELL_LOAD_IN
    } cell_op_t;

    typedef struct packed {
        cell_op_t op;
    } cell_ctrl_t;

endpackage

>>> design/pidl_cell.sv
`timescale 1ns / 1ps

module pidl_cell (
    input  logic                          aclk,
    input  pidl_pkg::cell_ctrl_t          ctrl,
    input  logic [pidl_pkg::DATA_W-1:0]   left_data,
    input  logic [pidl_pkg::DATA_W-1:0]   right_data,
    input  logic [pidl_pkg::DATA_W-1:0]   head_data,
    input  logic [pidl_pkg::DATA_W-1:0]   ins_data,
    output logic [pidl_pkg::DATA_W-1:0]   data_out
);
    import pidl_pkg::*;

    logic [DATA_W-1:0] data_reg;
    logic [DATA_W-1:0] data_next;

    always_comb begin
        case (ctrl.op)
            CELL_LOAD_LEFT:  data_next = left_data;
            CELL_LOAD_RIGHT: data_next = right_data;
            CELL_LOAD_HEAD:  data_next = head_data;
            CELL_LOAD_IN:    data_next = ins_data;
            default:         data_next = data_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        data_reg <= data_next;
    end

    assign data_out = data_reg;

endmodule

>>> design/positional_insert_delete_list.sv
`timescale 1ns / 1ps
// Insert, delete and invalid operations: result registered as the input is accepted.
// Throughput for those: one per cycle, outside a dump, while the result is taken.
// Dump: one result per cycle while results are taken; the cell chain rotates past its head.
// Reset: synchronous active-low; clears the element count, sets capacity to 16.
// Element cells have no reset; only held entries are ever read.

module positional_insert_delete_list (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               cfg_wr_en,
    input  logic [pidl_pkg::CAP_W-1:0]         cfg_wr_data,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // value_in[31:0], position_in[47:32]
    input  logic [pidl_pkg::S_TDATA_W-1:0]     s_axis_tdata,
    // opcode[1:0]
    input  logic [1:0]                         s_axis_tuser,
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // value_out[31:0], index_out[35:32], element_count[40:36], zeros above
    output logic [pidl_pkg::M_TDATA_W-1:0]     m_axis_tdata,
    // status[1:0]
    output logic [1:0]                         m_axis_tuser,
    output logic                               m_axis_tlast
);
    import pidl_pkg::*;

    typedef enum logic {
        S_IDLE,
        S_DUMP
    } state_t;

    state_t                 state_reg;
    logic [CNT_W-1:0]       count_reg;
    logic [CAP_W-1:0]       cap_reg;
    logic [IDX_W-1:0]       dump_idx_reg;
    logic                   m_valid_reg;
    status_t                status_reg;
    logic [DATA_W-1:0]      value_reg;
    logic [OUT_IDX_W-1:0]   idx_reg;
    logic [OUT_CNT_W-1:0]   cnt_reg;
    logic                   last_reg;

    logic [DATA_W-1:0]      cell_data [LIST_DEPTH];
    cell_ctrl_t             cell_ctrl [LIST_DEPTH];

    opcode_t                opcode;
    logic [DATA_W-1:0]      value_in;
    logic [POS_W-1:0]       pos_raw;
    logic                   pos_neg;
    logic                   pos_hi_zero;
    logic [CNT_W-1:0]       pos_lo;
    logic [CNT_W-1:0]       ins_pos;
    logic                   list_full;
    logic                   ins_ok;
    logic                   del_ok;
    logic                   out_free;
    logic                   accept;
    logic                   dump_step;
    logic                   dump_last;
    logic [CNT_W-1:0]       count_m1;

    assign opcode      = opcode_t'(s_axis_tuser);
    assign value_in    = s_axis_tdata[DATA_W-1:0];
    assign pos_raw     = s_axis_tdata[DATA_W+POS_W-1:DATA_W];
    assign pos_neg     = pos_raw[POS_W-1];
    assign pos_hi_zero = (pos_raw[POS_W-1:CNT_W] == '0);
    assign pos_lo      = pos_raw[CNT_W-1:0];
    assign ins_pos     = (!pos_hi_zero || (pos_lo > count_reg)) ? count_reg : pos_lo;
    assign list_full   = (count_reg >= CNT_W'(LIST_DEPTH)) ||
                         (CMP_W'(count_reg) >= CMP_W'(cap_reg));
    assign ins_ok      = !list_full && !pos_neg;
    assign del_ok      = (count_reg != '0) && pos_hi_zero && (pos_lo < count_reg);
    assign count_m1    = count_reg - CNT_W'(1);

    assign out_free      = !m_valid_reg || m_axis_tready;
    assign s_axis_tready = (state_reg == S_IDLE) && out_free;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign dump_step     = (state_reg == S_DUMP) && out_free;
    assign dump_last     = (CNT_W'(dump_idx_reg) == count_m1);

    always_comb begin
        for (int i = 0; i < LIST_DEPTH; i++) begin
            cell_ctrl[i].op = CELL_HOLD;
            if (accept && (opcode == OP_INSERT) && ins_ok) begin
                if (CNT_W'(i) > ins_pos) begin
                    cell_ctrl[i].op = CELL_LOAD_LEFT;
                end else if (CNT_W'(i) == ins_pos) begin
                    cell_ctrl[i].op = CELL_LOAD_IN;
                end
            end else if (accept && (opcode == OP_DELETE) && del_ok) begin
                if (CNT_W'(i) >= pos_lo) begin
                    cell_ctrl[i].op = CELL_LOAD_RIGHT;
                end
            end else if (dump_step) begin
                if (CNT_W'(i) == count_m1) begin
                    cell_ctrl[i].op = CELL_LOAD_HEAD;
                end else if (CNT_W'(i) < count_m1) begin
                    cell_ctrl[i].op = CELL_LOAD_RIGHT;
                end
            end
        end
    end

    for (genvar g = 0; g < LIST_DEPTH; g++) begin : g_cell
        logic [DATA_W-1:0] left_d;
        logic [DATA_W-1:0] right_d;
        if (g == 0) begin : g_first
            assign left_d = '0;
        end else begin : g_mid_l
            assign left_d = cell_data[g-1];
        end
        if (g == LIST_DEPTH - 1) begin : g_last
            assign right_d = '0;
        end else begin : g_mid_r
            assign right_d = cell_data[g+1];
        end
        pidl_cell u_cell (
            .aclk       (aclk),
            .ctrl       (cell_ctrl[g]),
            .left_data  (left_d),
            .right_data (right_d),
            .head_data  (cell_data[0]),
            .ins_data   (value_in),
            .data_out   (cell_data[g])
        );
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            count_reg    <= '0;
            cap_reg      <= CAP_W'(16);
            dump_idx_reg <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                cap_reg <= cfg_wr_data;
            end
            if (accept) begin
                last_reg <= 1'b1;
                case (opcode)
                    OP_INSERT: begin
                        m_valid_reg <= 1'b1;
                        value_reg   <= '0;
                        if (list_full) begin
                            status_reg <= ST_FULL;
                            idx_reg    <= '0;
                            cnt_reg    <= OUT_CNT_W'(count_reg);
                        end else if (pos_neg) begin
                            status_reg <= ST_BADPOS;
                            idx_reg    <= '0;
                            cnt_reg    <= OUT_CNT_W'(count_reg);
                        end else begin
                            status_reg <= ST_OK;
                            idx_reg    <= OUT_IDX_W'(ins_pos);
                            count_reg  <= count_reg + CNT_W'(1);
                            cnt_reg    <= OUT_CNT_W'(count_reg + CNT_W'(1));
                        end
                    end
                    OP_DELETE: begin
                        m_valid_reg <= 1'b1;
                        if (count_reg == '0) begin
                            status_reg <= ST_EMPTY;
                            value_reg  <= '0;
                            idx_reg    <= '0;
                            cnt_reg    <= OUT_CNT_W'(count_reg);
                        end else if (!del_ok) begin
                            status_reg <= ST_BADPOS;
                            value_reg  <= '0;
                            idx_reg    <= '0;
                            cnt_reg    <= OUT_CNT_W'(count_reg);
                        end else begin
                            status_reg <= ST_OK;
                            value_reg  <= cell_data[pos_lo[IDX_W-1:0]];
                            idx_reg    <= OUT_IDX_W'(pos_lo);
                            count_reg  <= count_m1;
                            cnt_reg    <= OUT_CNT_W'(count_m1);
                        end
                    end
                    OP_DUMP: begin
                        value_reg <= '0;
                        idx_reg   <= '0;
                        cnt_reg   <= OUT_CNT_W'(count_reg);
                        if (count_reg == '0) begin
                            m_valid_reg <= 1'b1;
                            status_reg  <= ST_EMPTY;
                        end else begin
                            m_valid_reg  <= 1'b0;
                            state_reg    <= S_DUMP;
                            dump_idx_reg <= '0;
                        end
                    end
                    default: begin
                        m_valid_reg <= 1'b1;
                        status_reg  <= ST_BADPOS;
                        value_reg   <= '0;
                        idx_reg     <= '0;
                        cnt_reg     <= OUT_CNT_W'(count_reg);
                    end
                endcase
            end else if (dump_step) begin
                m_valid_reg  <= 1'b1;
                status_reg   <= ST_OK;
                value_reg    <= cell_data[0];
                idx_reg      <= OUT_IDX_W'(dump_idx_reg);
                cnt_reg      <= OUT_CNT_W'(count_reg);
                last_reg     <= dump_last;
                dump_idx_reg <= dump_idx_reg + IDX_W'(1);
                if (dump_last) begin
                    state_reg <= S_IDLE;
                end
            end else if (m_axis_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = {(M_TDATA_W - DATA_W - OUT_IDX_W - OUT_CNT_W)'(0),
                            cnt_reg, idx_reg, value_reg};
    assign m_axis_tuser  = status_reg;
    assign m_axis_tlast  = last_reg;

endmodule

>>> test/testbench.sv
`timescale 1ns / 1ps

module testbench;
    import pidl_pkg::*;

    localparam int CYCLE_LIMIT = 300000;
    localparam int HOLD_CYCLES = 300;

    typedef enum int {
        RX_ALWAYS,
        RX_RANDOM,
        RX_PATTERN,
        RX_SPARSE
    } rx_mode_t;

    typedef struct {
        status_t     status;
        logic [31:0] value;
        logic [3:0]  index;
        logic [4:0]  count;
        logic        last;
    } list_result_t;

    class list_scoreboard;
        logic [31:0]  cells [LIST_DEPTH];
        int unsigned  held;
        int unsigned  capacity;
        list_result_t awaited[$];
        int           errors;
        int           reported;

        function new();
            held = 0;
            capacity = 16;
            errors = 0;
            reported = 0;
        endfunction

        function void set_capacity(int unsigned c);
            capacity = c;
        endfunction

        function int unsigned room();
            return (capacity < LIST_DEPTH) ? capacity : LIST_DEPTH;
        endfunction

        function void push(status_t st, logic [31:0] v, int unsigned idx, logic last);
            list_result_t r;
            r.status = st;
            r.value  = v;
            r.index  = idx[3:0];
            r.count  = held[4:0];
            r.last   = last;
            awaited.push_back(r);
        endfunction

        function void record_command(opcode_t op, logic [31:0] v, logic [15:0] pos);
            int unsigned p;
            logic [31:0] got;
            p = {16'd0, pos};
            case (op)
                OP_INSERT: begin
                    if (held >= room()) begin
                        push(ST_FULL, 0, 0, 1'b1);
                    end else if (pos[15]) begin
                        push(ST_BADPOS, 0, 0, 1'b1);
                    end else begin
                        if (p > held) p = held;
                        for (int i = held; i > p; i--) cells[i] = cells[i-1];
                        cells[p] = v;
                        held++;
                        push(ST_OK, 0, p, 1'b1);
                    end
                end
                OP_DELETE: begin
                    if (held == 0) begin
                        push(ST_EMPTY, 0, 0, 1'b1);
                    end else if (pos[15] || p >= held) begin
                        push(ST_BADPOS, 0, 0, 1'b1);
                    end else begin
                        got = cells[p];
                        for (int i = p; i + 1 < held; i++) cells[i] = cells[i+1];
                        held--;
                        push(ST_OK, got, p, 1'b1);
                    end
                end
                OP_DUMP: begin
                    if (held == 0) begin
                        push(ST_EMPTY, 0, 0, 1'b1);
                    end else begin
                        for (int i = 0; i < held; i++) push(ST_OK, cells[i], i, i + 1 == held);
                    end
                end
                default: push(ST_BADPOS, 0, 0, 1'b1);
            endcase
        endfunction

        function void check_response(status_t st, logic [31:0] v, logic [3:0] idx,
                                     logic [4:0] cnt, logic last);
            list_result_t e;
            if (awaited.size() == 0) begin
                errors++;
                if (reported < 10) begin
                    reported++;
                    $display("unexpected response: st=%0d val=%h idx=%0d cnt=%0d last=%b",
                             st, v, idx, cnt, last);
                end
                return;
            end
            e = awaited.pop_front();
            if (e.status !== st || e.value !== v || e.index !== idx ||
                e.count !== cnt || e.last !== last) begin
                errors++;
                if (reported < 10) begin
                    reported++;
                    $display("mismatch: exp st=%0d val=%h idx=%0d cnt=%0d last=%b",
                             e.status, e.value, e.index, e.count, e.last);
                    $display("          got st=%0d val=%h idx=%0d cnt=%0d last=%b",
                             st, v, idx, cnt, last);
                end
            end
        endfunction
    endclass

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 cfg_wr_en = 1'b0;
    logic [CAP_W-1:0]     cfg_wr_data = '0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [S_TDATA_W-1:0] s_axis_tdata = '0;
    logic [1:0]           s_axis_tuser = '0;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_axis_tdata;
    logic [1:0]           m_axis_tuser;
    logic                 m_axis_tlast;

    list_scoreboard sb;
    rx_mode_t       rx_mode = RX_ALWAYS;
    int             hold_request = 0;
    int             hold_left = 0;
    int unsigned    rx_phase = 0;
    int             cycle_count = 0;
    int             burst_left = 0;

    positional_insert_delete_list dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    initial begin
        forever #4 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // receiver: long hold-off first, otherwise the current stall pattern
    always @(negedge aclk) begin
        if (hold_request != 0) begin
            hold_left = hold_request;
            hold_request = 0;
        end
        rx_phase = rx_phase + 1;
        if (hold_left != 0) begin
            hold_left = hold_left - 1;
            m_axis_tready <= 1'b0;
        end else begin
            case (rx_mode)
                RX_ALWAYS:  m_axis_tready <= 1'b1;
                RX_RANDOM:  m_axis_tready <= 1'($urandom_range(0, 1));
                RX_PATTERN: m_axis_tready <= (rx_phase % 7) < 4;
                default:    m_axis_tready <= ($urandom_range(0, 7) == 0);
            endcase
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_axis_tvalid && m_axis_tready)
            sb.check_response(status_t'(m_axis_tuser), m_axis_tdata[31:0],
                              m_axis_tdata[35:32], m_axis_tdata[40:36], m_axis_tlast);
    end

    task send_command(input opcode_t op, input logic [31:0] v, input logic [15:0] pos);
        @(negedge aclk);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {pos, v};
        s_axis_tuser  <= op;
        @(posedge aclk);
        while (!s_axis_tready) @(posedge aclk);
        sb.record_command(op, v, pos);
    endtask

    task idle_sender(input int n);
        @(negedge aclk);
        s_axis_tvalid <= 1'b0;
        repeat (n - 1) @(negedge aclk);
    endtask

    task drain;
        @(negedge aclk);
        s_axis_tvalid <= 1'b0;
        while (sb.awaited.size() != 0) @(posedge aclk);
        repeat (LIST_DEPTH + 4) @(posedge aclk);
    endtask

    task write_capacity(input int unsigned c);
        @(negedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= c[CAP_W-1:0];
        @(negedge aclk);
        cfg_wr_en   <= 1'b0;
        sb.set_capacity(c);
    endtask

    function automatic logic [31:0] pick_value();
        case ($urandom_range(0, 11))
            0:       return 32'h7fff_ffff;
            1:       return 32'h8000_0000;
            2:       return 32'hffff_ffff;
            3:       return 32'h0;
            default: return $urandom();
        endcase
    endfunction

    function automatic logic [15:0] pick_position(input bit for_delete);
        int unsigned lim;
        int unsigned r;
        lim = (for_delete && sb.held != 0) ? sb.held - 1 : sb.held;
        r = $urandom_range(0, 19);
        if (r < 14) return 16'($urandom_range(0, lim));
        if (r < 16) return {1'b1, 15'($urandom())};
        if (r < 18) return {1'b0, 15'($urandom())};
        return (r == 18) ? 16'h7fff : 16'(lim + 1);
    endfunction

    task run_phase(input int unsigned cap, input int n, input int ins_pct,
                   input rx_mode_t mode, input bit gaps, input int hold);
        opcode_t op;
        int      r;
        drain();
        write_capacity(cap);
        @(posedge aclk);
        rx_mode = mode;
        hold_request = hold;
        burst_left = 0;
        for (int k = 0; k < n; k++) begin
            if (gaps && burst_left == 0) begin
                idle_sender($urandom_range(1, 6));
                burst_left = $urandom_range(1, 12);
            end
            r = $urandom_range(0, 99);
            if (r < 2)                         op = OP_BAD;
            else if (r < 12)                   op = OP_DUMP;
            else if (r < 12 + ins_pct * 88 / 100) op = OP_INSERT;
            else                               op = OP_DELETE;
            send_command(op, pick_value(), pick_position(op == OP_DELETE));
            if (burst_left > 0) burst_left--;
        end
    endtask

    initial begin
        sb = new();
        repeat (10) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        write_capacity(16);

        rx_mode = RX_RANDOM;
        send_command(OP_DUMP,   32'h1234_5678, 16'h0000);
        send_command(OP_DELETE, 32'h0,         16'h0000);
        send_command(OP_DELETE, 32'h0,         16'hffff);
        send_command(OP_BAD,    32'hdead_beef, 16'h0001);
        send_command(OP_INSERT, 32'h5555_aaaa, 16'hffff);
        send_command(OP_INSERT, 32'h7fff_ffff, 16'h0000);
        send_command(OP_INSERT, 32'h8000_0000, 16'h7fff);
        send_command(OP_INSERT, 32'hffff_ffff, 16'h0001);
        send_command(OP_INSERT, 32'h0,         16'h8000);
        send_command(OP_DELETE, 32'h0,         16'h0003);
        send_command(OP_DELETE, 32'h0,         16'hffff);
        send_command(OP_DELETE, 32'h0,         16'h7fff);
        send_command(OP_DUMP,   32'h0,         16'h0000);
        send_command(OP_DELETE, 32'h0,         16'h0001);
        send_command(OP_DUMP,   32'h0,         16'h0000);

        // capacity below the count: held elements stay, inserts report full
        drain();
        write_capacity(1);
        send_command(OP_INSERT, 32'h0bad_f00d, 16'h0000);
        send_command(OP_INSERT, 32'h0bad_f00d, 16'hfffb);
        send_command(OP_DUMP,   32'h0,         16'h0000);
        drain();
        write_capacity(0);
        send_command(OP_INSERT, 32'h1111_1111, 16'h0000);
        send_command(OP_DELETE, 32'h0,         16'h0000);
        send_command(OP_INSERT, 32'h2222_2222, 16'h0000);

        run_phase(16, 60, 60, RX_ALWAYS,  1'b0, 0);
        run_phase(16, 60, 50, RX_RANDOM,  1'b1, HOLD_CYCLES);
        run_phase(7,  50, 45, RX_PATTERN, 1'b1, 0);
        run_phase(1,  40, 55, RX_RANDOM,  1'b1, 0);
        run_phase(0,  25, 50, RX_SPARSE,  1'b1, 0);
        run_phase(12, 60, 65, RX_PATTERN, 1'b0, 0);
        run_phase(16, 60, 70, RX_RANDOM,  1'b1, 0);
        run_phase(4,  40, 30, RX_ALWAYS,  1'b1, 0);
        run_phase(16, 50, 50, RX_SPARSE,  1'b0, 0);
        drain();

        if (sb.errors == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
